### design/ohlc_bar_aggregator_assert.svh
// ----------------------------------------------------------------------------
// ohlc assertion macros
// shared concurrent assertion forms, clocked on clk; all but the reset form are held off during rst
// ----------------------------------------------------------------------------
`ifndef OHLC_BAR_AGGREGATOR_ASSERT_SVH
`define OHLC_BAR_AGGREGATOR_ASSERT_SVH

// same-cycle implication
`define OHLC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ohlc check failed");

// next-cycle implication
`define OHLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ohlc check failed");

// next-cycle implication that is also checked across reset
`define OHLC_ASSERT_RESET(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ohlc reset check failed");

`endif

### design/ohlc_pkg.sv
// ----------------------------------------------------------------------------
// ohlc package
// shared types, codes, constants and the minute alignment helper
// ----------------------------------------------------------------------------
`default_nettype none

package ohlc_pkg;

  localparam int DEF_PRICE_WIDTH = 32;
  localparam int DEF_DAY_WIDTH   = 16;
  localparam int QUEUE_DEPTH     = 4;

  localparam int unsigned STEP_5M  = 5;
  localparam int unsigned STEP_15M = 15;
  localparam int unsigned STEP_30M = 30;

  typedef enum logic [2:0] {
    PERIOD_1M = 3'd0,
    PERIOD_5M = 3'd1,
    PERIOD_15M = 3'd2,
    PERIOD_30M = 3'd3,
    PERIOD_1H = 3'd4,
    PERIOD_4H = 3'd5,
    PERIOD_1D = 3'd6
  } period_t;

  typedef enum logic [1:0] {
    KIND_PASS = 2'd0,
    KIND_AGG  = 2'd1,
    KIND_SKIP = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic       eod;
    logic [4:0] al_hour;
    logic [5:0] al_minute;
  } ctl_t;

  // largest multiple of Step not above m
  function automatic logic [5:0] floor_minute(input logic [5:0] m, input int unsigned Step);
    logic [5:0] r;
    r = '0;
    for (int unsigned k = Step; k < 64; k = k + Step) begin
      if (m >= 6'(k)) r = 6'(k);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/ohlc_queue.sv
// ----------------------------------------------------------------------------
// ohlc queue
// small word queue between the front and back parts, full flag decoded from the registered count
// ----------------------------------------------------------------------------
`default_nettype none

module ohlc_queue import ohlc_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic                  rvalid,
  output logic [WIDTH-1:0]      rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full   = (count == CW'(DEPTH));
  assign rvalid = (count != '0);
  assign rdata  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wdata;
  end

endmodule

`default_nettype wire

### design/ohlc_front.sv
// ----------------------------------------------------------------------------
// ohlc front
// holds the period register, accepts words and classifies them with their
// aligned period start
// ----------------------------------------------------------------------------
`default_nettype none

module ohlc_front import ohlc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] period_select,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [4:0] hour,
  input  wire logic [5:0] minute,
  input  wire logic       stamp_ok,
  input  wire logic       end_of_data,
  input  wire logic       q_full,
  output logic            push,
  output ctl_t            ctl
);

  logic [2:0] period;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign push      = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_1M;
    end else if (cfg_valid && cfg_ready) begin
      period <= period_select;
    end
  end

  always_comb begin
    ctl.eod       = end_of_data;
    ctl.kind      = stamp_ok ? KIND_AGG : KIND_SKIP;
    ctl.al_hour   = hour;
    ctl.al_minute = '0;
    case (period)
      PERIOD_1M:  ctl.kind = KIND_PASS;
      PERIOD_5M:  ctl.al_minute = floor_minute(minute, STEP_5M);
      PERIOD_15M: ctl.al_minute = floor_minute(minute, STEP_15M);
      PERIOD_30M: ctl.al_minute = floor_minute(minute, STEP_30M);
      PERIOD_1H:  ctl.al_minute = '0;
      PERIOD_4H:  ctl.al_hour = {hour[4:2], 2'b00};
      PERIOD_1D:  ctl.al_hour = '0;
      // unused selector: words are dropped, end of data still flushes
      default:    ctl.kind = KIND_SKIP;
    endcase
  end

endmodule

`default_nettype wire

### design/ohlc_back.sv
// ----------------------------------------------------------------------------
// ohlc back
// keeps the open bar, folds queued words into it and drives the result
// register
// ----------------------------------------------------------------------------
`default_nettype none

module ohlc_back import ohlc_pkg::*; #(
  parameter int PRICE_WIDTH = DEF_PRICE_WIDTH,
  parameter int DAY_WIDTH   = DEF_DAY_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_valid,
  output logic                        pop,
  input  wire ctl_t                   q_ctl,
  input  wire logic [DAY_WIDTH-1:0]   q_day,
  input  wire logic [4:0]             q_hour,
  input  wire logic [5:0]             q_minute,
  input  wire logic [5:0]             q_second,
  input  wire logic [PRICE_WIDTH-1:0] q_open,
  input  wire logic [PRICE_WIDTH-1:0] q_high,
  input  wire logic [PRICE_WIDTH-1:0] q_low,
  input  wire logic [PRICE_WIDTH-1:0] q_close,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [DAY_WIDTH-1:0]        bar_day,
  output logic [4:0]                  bar_hour,
  output logic [5:0]                  bar_minute,
  output logic [5:0]                  bar_second,
  output logic [PRICE_WIDTH-1:0]      bar_open,
  output logic [PRICE_WIDTH-1:0]      bar_high,
  output logic [PRICE_WIDTH-1:0]      bar_low,
  output logic [PRICE_WIDTH-1:0]      bar_close,
  output logic                        last_of_run
);

  // open bar
  logic                   pending, pending_next;
  logic                   flush_stage, flush_stage_next;
  logic [DAY_WIDTH-1:0]   al_day;
  logic [4:0]             al_hour;
  logic [5:0]             al_minute;
  logic [DAY_WIDTH-1:0]   first_day;
  logic [4:0]             first_hour;
  logic [5:0]             first_minute;
  logic [5:0]             first_second;
  logic [PRICE_WIDTH-1:0] acc_open, acc_high, acc_low, acc_close;

  // folded bar candidate
  logic                   go, slot_free, differ, fresh, load, emit, emit_acc, emit_last;
  logic                   out_valid_next;
  logic [DAY_WIDTH-1:0]   new_day;
  logic [4:0]             new_hour;
  logic [5:0]             new_minute;
  logic [5:0]             new_second;
  logic [PRICE_WIDTH-1:0] new_open, new_high, new_low;

  assign slot_free = !out_valid || !out_stall;
  assign go        = q_valid && slot_free;
  assign differ    = pending && ((q_day != al_day) || (q_ctl.al_hour != al_hour) ||
                                 (q_ctl.al_minute != al_minute));
  assign fresh     = !pending || differ;

  assign new_day    = fresh ? q_day    : first_day;
  assign new_hour   = fresh ? q_hour   : first_hour;
  assign new_minute = fresh ? q_minute : first_minute;
  assign new_second = fresh ? q_second : first_second;
  assign new_open   = fresh ? q_open   : acc_open;
  assign new_high   = (fresh || (q_high > acc_high)) ? q_high : acc_high;
  assign new_low    = (fresh || (q_low < acc_low))   ? q_low  : acc_low;

  always_comb begin
    pending_next     = pending;
    flush_stage_next = flush_stage;
    pop              = 1'b0;
    load             = 1'b0;
    emit             = 1'b0;
    emit_acc         = 1'b1;
    emit_last        = 1'b1;
    if (go) begin
      if (flush_stage) begin
        // second result of a word that both closed a bar and ended the data
        emit             = 1'b1;
        pending_next     = 1'b0;
        flush_stage_next = 1'b0;
        pop              = 1'b1;
      end else begin
        case (q_ctl.kind)
          KIND_PASS: begin
            emit = 1'b1;
            if (pending) begin
              emit_last    = 1'b0;
              pending_next = 1'b0;
            end else begin
              emit_acc = 1'b0;
              pop      = 1'b1;
            end
          end
          KIND_AGG: begin
            load = 1'b1;
            if (differ) begin
              emit             = 1'b1;
              emit_last        = !q_ctl.eod;
              pending_next     = 1'b1;
              flush_stage_next = q_ctl.eod;
              pop              = !q_ctl.eod;
            end else begin
              emit         = q_ctl.eod;
              emit_acc     = 1'b0;
              pending_next = !q_ctl.eod;
              pop          = 1'b1;
            end
          end
          default: begin
            emit         = q_ctl.eod && pending;
            pending_next = pending && !q_ctl.eod;
            pop          = 1'b1;
          end
        endcase
      end
    end
    out_valid_next = emit ? 1'b1 : (out_valid && out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending     <= 1'b0;
      flush_stage <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      pending     <= pending_next;
      flush_stage <= flush_stage_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      al_day       <= q_day;
      al_hour      <= q_ctl.al_hour;
      al_minute    <= q_ctl.al_minute;
      first_day    <= new_day;
      first_hour   <= new_hour;
      first_minute <= new_minute;
      first_second <= new_second;
      acc_open     <= new_open;
      acc_high     <= new_high;
      acc_low      <= new_low;
      acc_close    <= q_close;
    end
    if (emit) begin
      last_of_run <= emit_last;
      if (emit_acc) begin
        bar_day    <= first_day;
        bar_hour   <= first_hour;
        bar_minute <= first_minute;
        bar_second <= first_second;
        bar_open   <= acc_open;
        bar_high   <= acc_high;
        bar_low    <= acc_low;
        bar_close  <= acc_close;
      end else begin
        // passthrough word, or the freshly folded bar on end of data
        bar_day    <= new_day;
        bar_hour   <= new_hour;
        bar_minute <= new_minute;
        bar_second <= new_second;
        bar_open   <= new_open;
        bar_high   <= new_high;
        bar_low    <= new_low;
        bar_close  <= q_close;
      end
    end
  end

endmodule

`default_nettype wire

### design/ohlc_bar_aggregator.sv
// ----------------------------------------------------------------------------
// ohlc bar aggregator
// resamples one-minute ohlc bars into bars of a configured period
// ----------------------------------------------------------------------------
//  channel  signals                     direction  handshake
//  cfg      cfg_valid/cfg_ready         in         period_select write
//  in       in_valid/in_stall           in         one minute bar per word
//  out      out_valid/out_stall         out        one resampled bar per word
//
//  one input word per cycle while the queue has room; a word that yields two
//  results holds the back part until both are emitted. an input word passes
//  through the queue, and its result shows on the registered outputs.
//  in_stall is high only while the four-word queue is full.
//  reset clears the period register to passthrough, the queue and the open bar.
// ----------------------------------------------------------------------------
`default_nettype none

module ohlc_bar_aggregator import ohlc_pkg::*; #(
  parameter int PRICE_WIDTH = DEF_PRICE_WIDTH,
  parameter int DAY_WIDTH   = DEF_DAY_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [2:0]             period_select,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [DAY_WIDTH-1:0]   day_index,
  input  wire logic [4:0]             hour,
  input  wire logic [5:0]             minute,
  input  wire logic [5:0]             second,
  input  wire logic [PRICE_WIDTH-1:0] open_price,
  input  wire logic [PRICE_WIDTH-1:0] high_price,
  input  wire logic [PRICE_WIDTH-1:0] low_price,
  input  wire logic [PRICE_WIDTH-1:0] close_price,
  input  wire logic                   stamp_ok,
  input  wire logic                   end_of_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [DAY_WIDTH-1:0]        bar_day,
  output logic [4:0]                  bar_hour,
  output logic [5:0]                  bar_minute,
  output logic [5:0]                  bar_second,
  output logic [PRICE_WIDTH-1:0]      bar_open,
  output logic [PRICE_WIDTH-1:0]      bar_high,
  output logic [PRICE_WIDTH-1:0]      bar_low,
  output logic [PRICE_WIDTH-1:0]      bar_close,
  output logic                        last_of_run
);

  localparam int QW = $bits(ctl_t) + DAY_WIDTH + 5 + 6 + 6 + 4 * PRICE_WIDTH;

  ctl_t                   in_ctl, q_ctl;
  logic                   push, pop, q_full, q_valid;
  logic [QW-1:0]          q_wdata, q_rdata;
  logic [DAY_WIDTH-1:0]   q_day;
  logic [4:0]             q_hour;
  logic [5:0]             q_minute, q_second;
  logic [PRICE_WIDTH-1:0] q_open, q_high, q_low, q_close;

  ohlc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .period_select (period_select),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .hour          (hour),
    .minute        (minute),
    .stamp_ok      (stamp_ok),
    .end_of_data   (end_of_data),
    .q_full        (q_full),
    .push          (push),
    .ctl           (in_ctl)
  );

  assign q_wdata = {in_ctl, day_index, hour, minute, second,
                    open_price, high_price, low_price, close_price};

  ohlc_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  assign {q_ctl, q_day, q_hour, q_minute, q_second,
          q_open, q_high, q_low, q_close} = q_rdata;

  ohlc_back #(
    .PRICE_WIDTH (PRICE_WIDTH),
    .DAY_WIDTH   (DAY_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .pop         (pop),
    .q_ctl       (q_ctl),
    .q_day       (q_day),
    .q_hour      (q_hour),
    .q_minute    (q_minute),
    .q_second    (q_second),
    .q_open      (q_open),
    .q_high      (q_high),
    .q_low       (q_low),
    .q_close     (q_close),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .bar_day     (bar_day),
    .bar_hour    (bar_hour),
    .bar_minute  (bar_minute),
    .bar_second  (bar_second),
    .bar_open    (bar_open),
    .bar_high    (bar_high),
    .bar_low     (bar_low),
    .bar_close   (bar_close),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

### design/ohlc_checker.sv
// ----------------------------------------------------------------------------
// ohlc checker
// port-level checks on the bar aggregator, attached by bind
// ----------------------------------------------------------------------------
`default_nettype none

`include "ohlc_bar_aggregator_assert.svh"

module ohlc_checker import ohlc_pkg::*; #(
  parameter int PRICE_WIDTH = DEF_PRICE_WIDTH
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_stall,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic [PRICE_WIDTH-1:0] bar_close,
  input wire logic                   last_of_run
);

  // reset leaves no result word behind
  `OHLC_ASSERT_RESET(a_reset_clears_out, rst, !out_valid)

  // a stalled result word keeps its contents
  `OHLC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(bar_close) && $stable(last_of_run))

  // the second result of a word follows right after the first is taken
  `OHLC_ASSERT_NEXT(a_pair_follows, out_valid && !out_stall && !last_of_run, out_valid)

  // with no input word and no result word out, the queue cannot fill from a stall-free start
  `OHLC_ASSERT_NEXT(a_no_stall_when_idle, !in_valid && !in_stall && !out_valid, !in_stall)

endmodule

bind ohlc_bar_aggregator ohlc_checker #(
  .PRICE_WIDTH (PRICE_WIDTH)
) u_ohlc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .bar_close   (bar_close),
  .last_of_run (last_of_run)
);

`default_nettype wire
